// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the interrupt controller RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cond at every clock edge outside reset.
`define PIC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that ante at one edge implies cons at the next edge.
`define PIC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pic_pkg.sv -----
// Types and constants for the programmable interrupt controller.
// No dependencies; used by the core and top level.
package pic_pkg;

  localparam logic [1:0] REQ_NONE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_ACK   = 2'd3;

  localparam logic [1:0] INIT_IDLE = 2'd0;
  localparam logic [1:0] INIT_ICW2 = 2'd1;
  localparam logic [1:0] INIT_ICW4 = 2'd2;

  localparam logic [2:0] OCW2_NS_EOI     = 3'b001;
  localparam logic [2:0] OCW2_SPEC_EOI   = 3'b011;
  localparam logic [2:0] OCW2_ROT_NS_EOI = 3'b101;
  localparam logic [2:0] OCW2_ROT_SP_EOI = 3'b111;

  localparam logic [1:0] CMD_OCW2 = 2'b00;
  localparam logic [1:0] CMD_OCW3 = 2'b01;

  localparam logic [7:0] VECTOR_RESET = 8'h08;
  localparam logic [7:0] VECTOR_MASK  = 8'hF8;
  localparam logic [7:0] VECTOR_NONE  = 8'hFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic       port_a0;
    logic [7:0] write_data;
    logic [7:0] irq_levels;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] ack_vector;
    logic       int_request;
  } result_t;

endpackage

// ----- rtl/pic_in_if.sv -----
// Input channel of the interrupt controller: valid/ready plus item fields.
// Depends on nothing; field widths follow pic_pkg::item_t.
interface pic_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       port_a0;
  logic [7:0] write_data;
  logic [7:0] irq_levels;

  modport source (output valid, req_type, port_a0, write_data, irq_levels, input ready);
  modport sink (input valid, req_type, port_a0, write_data, irq_levels, output ready);
endinterface

// ----- rtl/pic_out_if.sv -----
// Result channel of the interrupt controller: valid/ready plus result fields.
// Depends on nothing; field widths follow pic_pkg::result_t.
interface pic_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] ack_vector;
  logic       int_request;

  modport source (output valid, read_data, ack_vector, int_request, input ready);
  modport sink (input valid, read_data, ack_vector, int_request, output ready);
endinterface

// ----- rtl/pic_prio.sv -----
// Rotating priority resolver: highest-priority set line counting from base.
// Standalone; used by pic_core for acknowledge and end-of-interrupt.
module pic_prio (
  input  logic [7:0] bits,
  input  logic [2:0] base,
  output logic       hit,
  output logic [2:0] line
);

  logic [15:0] dbl;
  logic [7:0]  rot;
  logic [2:0]  k;

  always_comb begin
    dbl = {bits, bits} >> base;
    rot = dbl[7:0];
    k   = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (rot[i]) begin
        k = 3'(i);
      end
    end
    hit  = |bits;
    line = k + base;
  end

endmodule

// ----- rtl/pic_core.sv -----
// Controller state and the per-item update: edge capture, bus access, acknowledge.
// Depends on pic_pkg, pic_prio and assert_macros.svh.
`include "assert_macros.svh"

module pic_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pic_pkg::item_t   item,
  output pic_pkg::result_t result
);

  logic [7:0] request_r, request_nxt;
  logic [7:0] service_r, service_nxt;
  logic [7:0] mask_r, mask_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic [2:0] base_r, base_nxt;
  logic       sel_isr_r, sel_isr_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       icw4_r, icw4_nxt;
  logic [7:0] vector_r, vector_nxt;
  logic       aeoi_r, aeoi_nxt;

  logic [7:0] req_edge;
  logic       ack_hit;
  logic [2:0] ack_line;
  logic       isr_hit;
  logic [2:0] isr_line;
  logic [7:0] ack_bit;
  logic       is_icw1;
  logic       is_ack_hit;

  assign req_edge   = request_r | (item.irq_levels & ~prev_r);
  assign ack_bit    = 8'(1) << ack_line;
  assign is_icw1    = accept && item.req_type == pic_pkg::REQ_WRITE && !item.port_a0
                      && item.write_data[4];
  assign is_ack_hit = accept && item.req_type == pic_pkg::REQ_ACK && ack_hit;

  pic_prio u_ack_prio (
    .bits (req_edge & ~mask_r),
    .base (base_r),
    .hit  (ack_hit),
    .line (ack_line)
  );

  pic_prio u_isr_prio (
    .bits (service_r),
    .base (base_r),
    .hit  (isr_hit),
    .line (isr_line)
  );

  always_comb begin
    logic [2:0] lvl;
    lvl = item.write_data[2:0];

    request_nxt = req_edge;
    service_nxt = service_r;
    mask_nxt    = mask_r;
    prev_nxt    = item.irq_levels;
    base_nxt    = base_r;
    sel_isr_nxt = sel_isr_r;
    phase_nxt   = phase_r;
    icw4_nxt    = icw4_r;
    vector_nxt  = vector_r;
    aeoi_nxt    = aeoi_r;

    result.read_data  = 8'h00;
    result.ack_vector = 8'h00;

    case (item.req_type)
      pic_pkg::REQ_READ: begin
        if (item.port_a0) begin
          result.read_data = mask_r;
        end else begin
          result.read_data = sel_isr_r ? service_r : req_edge;
        end
      end
      pic_pkg::REQ_WRITE: begin
        if (!item.port_a0) begin
          if (item.write_data[4]) begin
            phase_nxt   = pic_pkg::INIT_ICW2;
            icw4_nxt    = item.write_data[0];
            request_nxt = 8'h00;
            service_nxt = 8'h00;
            mask_nxt    = 8'h00;
            prev_nxt    = 8'h00;
            base_nxt    = 3'd0;
            sel_isr_nxt = 1'b0;
            aeoi_nxt    = 1'b0;
          end else if (item.write_data[4:3] == pic_pkg::CMD_OCW3) begin
            if (item.write_data[1]) begin
              sel_isr_nxt = item.write_data[0];
            end
          end else begin
            case (item.write_data[7:5])
              pic_pkg::OCW2_NS_EOI: begin
                if (isr_hit) begin
                  service_nxt = service_r & ~(8'(1) << isr_line);
                end
              end
              pic_pkg::OCW2_SPEC_EOI: begin
                service_nxt = service_r & ~(8'(1) << lvl);
              end
              pic_pkg::OCW2_ROT_NS_EOI: begin
                if (isr_hit) begin
                  service_nxt = service_r & ~(8'(1) << isr_line);
                  base_nxt    = isr_line + 3'd1;
                end
              end
              pic_pkg::OCW2_ROT_SP_EOI: begin
                service_nxt = service_r & ~(8'(1) << lvl);
                base_nxt    = lvl + 3'd1;
              end
              default: begin
              end
            endcase
          end
        end else begin
          case (phase_r)
            pic_pkg::INIT_ICW2: begin
              vector_nxt = item.write_data & pic_pkg::VECTOR_MASK;
              phase_nxt  = icw4_r ? pic_pkg::INIT_ICW4 : pic_pkg::INIT_IDLE;
            end
            pic_pkg::INIT_ICW4: begin
              aeoi_nxt  = item.write_data[1];
              phase_nxt = pic_pkg::INIT_IDLE;
            end
            default: begin
              phase_nxt = pic_pkg::INIT_IDLE;
              mask_nxt  = item.write_data;
            end
          endcase
        end
      end
      pic_pkg::REQ_ACK: begin
        if (ack_hit) begin
          request_nxt = req_edge & ~ack_bit;
          if (!aeoi_r) begin
            service_nxt = service_r | ack_bit;
          end
          result.ack_vector = vector_r + {5'd0, ack_line};
        end else begin
          result.ack_vector = pic_pkg::VECTOR_NONE;
        end
      end
      default: begin
      end
    endcase

    result.int_request = |(request_nxt & ~mask_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      request_r <= 8'h00;
      service_r <= 8'h00;
      mask_r    <= 8'h00;
      prev_r    <= 8'h00;
      base_r    <= 3'd0;
      sel_isr_r <= 1'b0;
      phase_r   <= pic_pkg::INIT_IDLE;
      icw4_r    <= 1'b0;
      vector_r  <= pic_pkg::VECTOR_RESET;
      aeoi_r    <= 1'b0;
    end else if (accept) begin
      request_r <= request_nxt;
      service_r <= service_nxt;
      mask_r    <= mask_nxt;
      prev_r    <= prev_nxt;
      base_r    <= base_nxt;
      sel_isr_r <= sel_isr_nxt;
      phase_r   <= phase_nxt;
      icw4_r    <= icw4_nxt;
      vector_r  <= vector_nxt;
      aeoi_r    <= aeoi_nxt;
    end
  end

  `PIC_ASSERT_NEXT(a_icw1_clears, is_icw1,
    request_r == 8'h00 && service_r == 8'h00 && mask_r == 8'h00 &&
    phase_r == pic_pkg::INIT_ICW2, "ICW1 did not clear the controller")
  `PIC_ASSERT_NEXT(a_ack_moves_line, rst_n && is_ack_hit,
    (request_r & $past(ack_bit)) == 8'h00 &&
    ($past(aeoi_r) || (service_r & $past(ack_bit)) != 8'h00),
    "acknowledged line not moved to in-service")
  `PIC_ASSERT_NEXT(a_idle_holds, rst_n && !accept,
    $stable(request_r) && $stable(service_r) && $stable(mask_r) && $stable(base_r),
    "state changed without a transfer")

endmodule

// ----- rtl/programmable_interrupt_controller.sv -----
// Eight-line programmable interrupt controller, single mode.
// Channels: in_ch (sink) takes one item per transfer: request type, port
// address bit, write byte and the eight request line levels. out_ch
// (source) returns exactly one result per item: read byte, acknowledge
// vector and the pending-interrupt flag.
// Each result is registered at its input transfer. Throughput is one item
// per cycle while in_ch is ready; the priority resolvers and register
// update are combinational between input transfer and result register.
// A two-entry output buffer (result register plus skid register) keeps
// in_ch ready while one result waits; in_ch drops ready only when both
// entries are full, and rises again the cycle after out_ch takes a result.
// Reset (rst_n low, synchronous) clears request, in-service and mask
// registers, the priority base, read select and init sequence, sets the
// vector base to 0x08 and empties the output buffer.
// Depends on pic_pkg, pic_in_if, pic_out_if, pic_core, assert_macros.svh.
`include "assert_macros.svh"

module programmable_interrupt_controller (
  input  logic      clk,
  input  logic      rst_n,
  pic_in_if.sink    in_ch,
  pic_out_if.source out_ch
);

  pic_pkg::item_t   item;
  pic_pkg::result_t res_new;
  pic_pkg::result_t out_data_r;
  pic_pkg::result_t skid_data_r;
  logic             out_valid_r;
  logic             skid_valid_r;
  logic             accept;
  logic             pop;

  assign in_ch.ready = !skid_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = out_valid_r && out_ch.ready;

  assign item.req_type   = in_ch.req_type;
  assign item.port_a0    = in_ch.port_a0;
  assign item.write_data = in_ch.write_data;
  assign item.irq_levels = in_ch.irq_levels;

  pic_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (item),
    .result (res_new)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          out_data_r   <= skid_data_r;
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (!out_valid_r || pop) begin
          out_data_r  <= res_new;
          out_valid_r <= 1'b1;
        end else begin
          skid_data_r  <= res_new;
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_data_r.read_data;
  assign out_ch.ack_vector  = out_data_r.ack_vector;
  assign out_ch.int_request = out_data_r.int_request;

  `PIC_ASSERT(a_skid_behind_out, !skid_valid_r || out_valid_r,
    "skid entry held without a result in front of it")
  `PIC_ASSERT_NEXT(a_accept_fills, accept, out_valid_r,
    "transfer accepted but no result registered")

endmodule
